### hw/rtl/elementary_ca_ring_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elementary CA ring sequencer
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ELEMENTARY_CA_RING_SEQUENCER_UNIT_ASSERT_SVH
`define ELEMENTARY_CA_RING_SEQUENCER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define ECARS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent
`define ECARS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ecars_pkg.sv
// ----------------------------------------------------------------------------
// ecars_pkg
// Shared constants and types of the elementary CA ring sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ecars_pkg;

  // Ring size, fixed by the widths of the cell fields
  localparam int unsigned CELLS = 8;
  localparam int unsigned CntW  = 4;
  localparam int unsigned RuleW = 8;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  // Per-transaction control broadcast along the row of cells
  typedef struct packed {
    logic             accept;
    logic             step;
    logic [RuleW-1:0] rule;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/elementary_ca_ring_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Elementary CA ring sequencer
// Ring of eight automaton cells with step, toggle and force controls, and
// a report of both generations per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one tick: a rising edge on the step button or
// the step gate moves generation A into B and computes new A from the rule,
// toggle edges then flip A or B cells, and force levels set A cells live.
// Every transaction yields exactly one result transaction carrying both
// generations, their XOR/OR/AND, live counts and the bit-ordered numbers.
// The block takes one transaction per clock cycle while the output buffer
// has room; all cells update in parallel within that cycle, and the result
// is registered in the output buffer before it appears on the master side.
// A two-entry output buffer lets one result wait while the next transaction
// is accepted; the slave side stalls only when both entries are full.
`default_nettype none

module elementary_ca_ring_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // step_button, step_gate, rule_bits[7:0], scan_reverse, toggle_buttons[15:0],
  // force_live[7:0], zero pad
  input  logic [ecars_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // cells_a[7:0], cells_b[7:0], gates_xor[7:0], gates_or[7:0], gates_and[7:0],
  // live_count_a[3:0], live_count_b[3:0], ordered_a[7:0], ordered_b[7:0],
  // step_active, zero pad
  output logic [ecars_pkg::OutDataW-1:0]     m_axis_tdata_o
);
  import ecars_pkg::*;

`include "elementary_ca_ring_sequencer_unit_assert.svh"

  logic             step_button, step_gate, scan_reverse;
  logic [RuleW-1:0] rule_bits;
  logic [2*CELLS-1:0] toggle_buttons;
  logic [CELLS-1:0] force_live;

  logic             accept, step;
  logic             btn_q, gate_q;
  cell_ctrl_t       ctrl;

  logic [CELLS-1:0] a_q_vec, b_q_vec, a_next, b_next;
  logic [CELLS-1:0] ordered_a, ordered_b;
  logic [CntW-1:0]  live_count_a, live_count_b;
  logic [OutDataW-1:0] result;

  // Unpack the input payload
  assign step_button    = s_axis_tdata_i[0];
  assign step_gate      = s_axis_tdata_i[1];
  assign rule_bits      = s_axis_tdata_i[9:2];
  assign scan_reverse   = s_axis_tdata_i[10];
  assign toggle_buttons = s_axis_tdata_i[26:11];
  assign force_live     = s_axis_tdata_i[34:27];

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  // Detect a rising step edge on either source
  assign step = (step_button & ~btn_q) | (step_gate & ~gate_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q  <= 1'b0;
      gate_q <= 1'b0;
    end else if (accept) begin
      btn_q  <= step_button;
      gate_q <= step_gate;
    end
  end

  assign ctrl = '{accept: accept, step: step, rule: rule_bits};

  // Row of cells closed into a ring
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ecars_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .left_i   (a_q_vec[(i + CELLS - 1) % CELLS]),
      .right_i  (a_q_vec[(i + 1) % CELLS]),
      .tog_a_i  (toggle_buttons[i]),
      .tog_b_i  (toggle_buttons[CELLS + i]),
      .force_i  (force_live[i]),
      .a_q_o    (a_q_vec[i]),
      .b_q_o    (b_q_vec[i]),
      .a_next_o (a_next[i]),
      .b_next_o (b_next[i])
    );
  end

  // Count live cells and order the number outputs
  always_comb begin
    live_count_a = '0;
    live_count_b = '0;
    for (int unsigned i = 0; i < CELLS; i++) begin
      live_count_a = live_count_a + CntW'(a_next[i]);
      live_count_b = live_count_b + CntW'(b_next[i]);
      ordered_a[i] = scan_reverse ? a_next[CELLS-1-i] : a_next[i];
      ordered_b[i] = scan_reverse ? b_next[CELLS-1-i] : b_next[i];
    end
  end

  // Pack the result payload
  assign result = {7'b0, step_button | step_gate, ordered_b, ordered_a,
                   live_count_b, live_count_a, a_next & b_next, a_next | b_next,
                   a_next ^ b_next, b_next, a_next};

  ecars_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // A step without B toggles moves the old A generation into B
  `ECARS_ASSERT_NEXT(a_step_shift, clk_i, rst_ni,
    accept && step && (toggle_buttons[2*CELLS-1:CELLS] == '0),
    b_q_vec == $past(a_q_vec), "step did not move generation A into B")
  // Cell state holds between transactions
  `ECARS_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !accept,
    $stable(a_q_vec) && $stable(b_q_vec) && $stable(btn_q) && $stable(gate_q),
    "cell state changed without a transaction")
  // Forced cells are live after the transaction
  `ECARS_ASSERT_NEXT(a_force_live, clk_i, rst_ni, accept,
    (a_q_vec & $past(force_live)) == $past(force_live),
    "forced cell not live")

endmodule

`default_nettype wire

### hw/rtl/ecars_cell.sv
// ----------------------------------------------------------------------------
// ecars_cell
// One ring position: holds its current and previous generation bit plus the
// toggle edge history, and applies step, toggle and force on each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ecars_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ecars_pkg::cell_ctrl_t  ctrl_i,
  input  logic                   left_i,     // current bit of left neighbour
  input  logic                   right_i,    // current bit of right neighbour
  input  logic                   tog_a_i,
  input  logic                   tog_b_i,
  input  logic                   force_i,
  output logic                   a_q_o,
  output logic                   b_q_o,
  output logic                   a_next_o,
  output logic                   b_next_o
);
  import ecars_pkg::*;

  logic a_q, a_d;
  logic b_q, b_d;
  logic tga_q, tgb_q;
  logic a_step, b_step;
  logic [2:0] nbh;

  // Step: look up the rule for the neighbourhood, shift A into B
  assign nbh    = {left_i, a_q, right_i};
  assign a_step = ctrl_i.step ? ctrl_i.rule[nbh] : a_q;
  assign b_step = ctrl_i.step ? a_q : b_q;

  // Toggle on rising edges, then force A live
  assign a_d = (a_step ^ (tog_a_i & ~tga_q)) | force_i;
  assign b_d = b_step ^ (tog_b_i & ~tgb_q);

  // Advance state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= 1'b0;
      b_q   <= 1'b0;
      tga_q <= 1'b0;
      tgb_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      a_q   <= a_d;
      b_q   <= b_d;
      tga_q <= tog_a_i;
      tgb_q <= tog_b_i;
    end
  end

  assign a_q_o    = a_q;
  assign b_q_o    = b_q;
  assign a_next_o = a_d;
  assign b_next_o = b_d;

endmodule

`default_nettype wire

### hw/rtl/ecars_skid.sv
// ----------------------------------------------------------------------------
// ecars_skid
// Two-entry output buffer: an output register plus a skid register, so the
// input side keeps accepting while one result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module ecars_skid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ecars_pkg::OutDataW-1:0]     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ecars_pkg::OutDataW-1:0]     out_data_o
);
  import ecars_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  logic [OutDataW-1:0] out_q, out_d;
  logic [OutDataW-1:0] skid_q, skid_d;
  logic                push, pop;

  assign in_ready_o = ~skid_valid_q;
  assign push       = in_valid_i & ~skid_valid_q;
  assign pop        = out_valid_q & out_ready_i;

  // Refill the output register from the skid entry first, then the input
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push;
        skid_d       = in_data_i;
      end else begin
        out_valid_d  = push;
        out_d        = in_data_i;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
